// ===== sv/ppwc_pkg.sv =====
// Shared types and constants for the planar pixel write combiner.
package ppwc_pkg;

  localparam int unsigned NUM_PLANES  = 4;
  localparam int unsigned PLANE_BYTES = 8;
  localparam int unsigned BYTE_IDX_W  = 3;
  // Pixel count of a run, wide enough for the largest run of 64 pixels
  localparam int unsigned LEN_IDX_W   = 7;
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned LIN_W       = 19;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic OP_MASKED = 1'b0;
  localparam logic OP_PLANE  = 1'b1;

  localparam logic [7:0] MASK_LEFT  = 8'h80;
  localparam logic [7:0] MASK_FULL  = 8'hFF;
  localparam logic [3:0] ALIGN_MASK = 4'hF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_BYTES,
    ST_BITS
  } ppwc_state_e;

  // What happens to the pending pixel once a run flush completes
  typedef enum logic [1:0] {
    POST_NONE,
    POST_START,
    POST_CACHE
  } ppwc_post_e;

  typedef struct packed {
    logic in_load;
    logic emit_cache;
    logic emit_byte;
    logic emit_bit;
    logic last;
    logic cache_merge;
    logic cache_set;
    logic cache_clear;
    logic run_begin;
    logic run_extend;
    logic run_clear;
    logic flush_init;
  } ppwc_cmd_t;

  typedef struct packed {
    logic kind;
    logic run_active;
    logic contiguous;
    logic run_full;
    logic cache_valid;
    logic cache_hit;
    logic x_aligned;
    logic has_bytes;
    logic has_bits;
    logic bytes_end;
    logic bits_end;
  } ppwc_status_t;

endpackage

// ===== sv/ppwc_ctrl.sv =====
// Controller state machine: decides per item and sequences run flushes.
module ppwc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  ppwc_pkg::ppwc_status_t status_i,
  output ppwc_pkg::ppwc_cmd_t    cmd_o
);
  import ppwc_pkg::*;

  ppwc_state_e state_q, state_d;
  ppwc_post_e  post_q, post_d;
  logic        flush_now;

  // a pending run goes out on flush, on a break, or when it is full
  assign flush_now = status_i.run_active &&
                     (status_i.kind || !status_i.contiguous || status_i.run_full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      post_q  <= POST_NONE;
    end else begin
      state_q <= state_d;
      post_q  <= post_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    post_d  = post_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (flush_now) begin
          state_d = status_i.has_bytes ? ST_BYTES : ST_BITS;
          if (status_i.kind) begin
            post_d = POST_NONE;
          end else if (status_i.contiguous || status_i.x_aligned) begin
            post_d = POST_START;
          end else begin
            post_d = POST_CACHE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_BYTES: begin
        if (status_i.bytes_end) state_d = status_i.has_bits ? ST_BITS : ST_IDLE;
      end
      ST_BITS: begin
        if (status_i.bits_end) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    logic finish;
    finish = 1'b0;
    cmd_o  = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_load = start_i;
      end
      ST_DECIDE: begin
        priority if (flush_now) begin
          cmd_o.flush_init = 1'b1;
        end else if (status_i.run_active) begin
          cmd_o.run_extend = 1'b1;
        end else if (status_i.kind) begin
          cmd_o.emit_cache  = status_i.cache_valid;
          cmd_o.last        = status_i.cache_valid;
          cmd_o.cache_clear = 1'b1;
        end else if (status_i.cache_hit) begin
          cmd_o.cache_merge = 1'b1;
        end else begin
          cmd_o.emit_cache = status_i.cache_valid;
          cmd_o.last       = status_i.cache_valid;
          if (status_i.x_aligned) begin
            cmd_o.run_begin = 1'b1;
          end else begin
            cmd_o.cache_set = 1'b1;
          end
        end
      end
      ST_BYTES: begin
        cmd_o.emit_byte = 1'b1;
        finish = status_i.bytes_end && !status_i.has_bits;
      end
      ST_BITS: begin
        cmd_o.emit_bit = 1'b1;
        finish = status_i.bits_end;
      end
      default: ;
    endcase
    if (finish) begin
      cmd_o.last      = 1'b1;
      cmd_o.run_clear = 1'b1;
      unique case (post_q)
        POST_START: cmd_o.run_begin = 1'b1;
        POST_CACHE: cmd_o.cache_set = 1'b1;
        default: ;
      endcase
    end
  end

  assign busy_o = (state_q != ST_IDLE);

`ifndef NO_ASSERTIONS
  a_decide_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DECIDE |=> state_q != ST_DECIDE)
    else $error("decide state repeated");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.last |-> (cmd_o.emit_cache || cmd_o.emit_byte || cmd_o.emit_bit))
    else $error("last flag without a beat");
`endif

endmodule

// ===== sv/ppwc_dp.sv =====
// Datapath: input registers, write cache, plane buffers, flush counters, result register.
module ppwc_dp #(
  parameter int unsigned RUN_PIXELS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ppwc_pkg::ppwc_cmd_t    cmd_i,
  output ppwc_pkg::ppwc_status_t status_o,
  input  logic                   kind_i,
  input  logic [9:0]             pixel_x_i,
  input  logic [8:0]             pixel_y_i,
  input  logic [3:0]             pixel_color_i,
  output logic                   strobe_o,
  output logic                   write_op_o,
  output logic [15:0]            byte_address_o,
  output logic [7:0]             bit_mask_o,
  output logic [3:0]             write_color_o,
  output logic [1:0]             plane_index_o,
  output logic [7:0]             plane_data_o,
  output logic                   last_o
);
  import ppwc_pkg::*;

  localparam int unsigned LEN_W = $clog2(RUN_PIXELS + 1);

  // latched item
  logic              kind_q;
  logic [3:0]        x_low_q;
  logic [3:0]        color_q;
  logic [ADDR_W-1:0] addr_q;
  logic [LIN_W-1:0]  lin_q;

  // write cache
  logic              cache_valid_q;
  logic [ADDR_W-1:0] cache_addr_q;
  logic [3:0]        cache_color_q;
  logic [7:0]        cache_mask_q;

  // run state
  logic [LIN_W-1:0]  run_start_q;
  logic [LIN_W:0]    run_end_q;
  logic [LEN_W-1:0]  run_len_q;
  logic [NUM_PLANES-1:0][7:0] plane_buf_q [PLANE_BYTES];

  // flush counters
  logic [1:0]            plane_q;
  logic [BYTE_IDX_W-1:0] byte_q;
  logic [2:0]            bitk_q;

  logic [LEN_IDX_W-1:0]  len_ext;
  logic [LEN_IDX_W-1:0]  wr_idx;
  logic [3:0]            whole;
  logic [2:0]            lo;
  logic                  byte_last;
  logic [ADDR_W-1:0]     run_base;
  logic [7:0]            pix_bit;
  logic [BYTE_IDX_W-1:0] rd_idx;
  logic [NUM_PLANES-1:0][7:0] rd_word;
  logic [3:0]            bit_color;

  assign len_ext   = LEN_IDX_W'(run_len_q);
  assign whole     = len_ext[LEN_IDX_W-1:BYTE_IDX_W];
  assign lo        = len_ext[2:0];
  assign byte_last = ({1'b0, byte_q} == (whole - 4'd1));
  assign run_base  = run_start_q[LIN_W-1:3];
  assign pix_bit   = MASK_LEFT >> x_low_q[2:0];
  assign wr_idx    = cmd_i.run_begin ? '0 : len_ext;

  // one read port over the buffer rows
  assign rd_idx  = cmd_i.emit_bit ? whole[BYTE_IDX_W-1:0] : byte_q;
  assign rd_word = plane_buf_q[rd_idx];

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      bit_color[p] = rd_word[p][~bitk_q];
    end
  end

  always_comb begin
    status_o             = '0;
    status_o.kind        = kind_q;
    status_o.run_active  = (run_len_q != '0);
    status_o.contiguous  = ({1'b0, lin_q} == run_end_q);
    status_o.run_full    = (run_len_q >= LEN_W'(RUN_PIXELS));
    status_o.cache_valid = cache_valid_q;
    status_o.cache_hit   = cache_valid_q && (cache_color_q == color_q) &&
                           (cache_addr_q == addr_q);
    status_o.x_aligned   = ((x_low_q & ALIGN_MASK) == 4'd0);
    status_o.has_bytes   = (whole != 4'd0);
    status_o.has_bits    = (lo != 3'd0);
    status_o.bytes_end   = byte_last && (plane_q == 2'd0);
    status_o.bits_end    = (bitk_q == 3'd0);
  end

  // item registers: address and linear position by shift-add
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      kind_q  <= kind_i;
      x_low_q <= pixel_x_i[3:0];
      color_q <= pixel_color_i;
      addr_q  <= (ADDR_W'(pixel_y_i) << 6) + (ADDR_W'(pixel_y_i) << 4) +
                 ADDR_W'(pixel_x_i[9:3]);
      lin_q   <= (LIN_W'(pixel_y_i) << 9) + (LIN_W'(pixel_y_i) << 7) +
                 LIN_W'(pixel_x_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_valid_q <= 1'b0;
      run_len_q     <= '0;
      strobe_o      <= 1'b0;
    end else begin
      if (cmd_i.cache_set) begin
        cache_valid_q <= 1'b1;
      end else if (cmd_i.cache_clear || cmd_i.run_clear || cmd_i.run_begin) begin
        cache_valid_q <= 1'b0;
      end
      if (cmd_i.run_begin) begin
        run_len_q <= LEN_W'(1);
      end else if (cmd_i.run_clear) begin
        run_len_q <= '0;
      end else if (cmd_i.run_extend) begin
        run_len_q <= run_len_q + LEN_W'(1);
      end
      strobe_o <= cmd_i.emit_cache || cmd_i.emit_byte || cmd_i.emit_bit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cache_set) begin
      cache_addr_q  <= addr_q;
      cache_color_q <= color_q;
      cache_mask_q  <= pix_bit;
    end else if (cmd_i.cache_merge) begin
      cache_mask_q  <= cache_mask_q | pix_bit;
    end
    if (cmd_i.run_begin) begin
      run_start_q <= lin_q;
      run_end_q   <= {1'b0, lin_q} + (LIN_W + 1)'(1);
    end else if (cmd_i.run_extend) begin
      run_end_q   <= run_end_q + (LIN_W + 1)'(1);
    end
    if (cmd_i.run_begin || cmd_i.run_extend) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        plane_buf_q[wr_idx[5:3]][p][~wr_idx[2:0]] <= color_q[p];
      end
    end
  end

  // flush walk: plane 3 down to 0, bytes ascending, then leftover bits
  always_ff @(posedge clk_i) begin
    if (cmd_i.flush_init) begin
      plane_q <= 2'(NUM_PLANES - 1);
      byte_q  <= '0;
      bitk_q  <= lo - 3'd1;
    end else if (cmd_i.emit_byte) begin
      if (byte_last) begin
        byte_q  <= '0;
        plane_q <= plane_q - 2'd1;
      end else begin
        byte_q  <= byte_q + BYTE_IDX_W'(1);
      end
    end else if (cmd_i.emit_bit) begin
      bitk_q <= bitk_q - 3'd1;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_cache || cmd_i.emit_byte || cmd_i.emit_bit) begin
      last_o <= cmd_i.last;
      priority if (cmd_i.emit_byte) begin
        write_op_o     <= OP_PLANE;
        byte_address_o <= run_base + ADDR_W'(byte_q);
        bit_mask_o     <= MASK_FULL;
        write_color_o  <= '0;
        plane_index_o  <= plane_q;
        plane_data_o   <= rd_word[plane_q];
      end else if (cmd_i.emit_bit) begin
        write_op_o     <= OP_MASKED;
        byte_address_o <= run_base + ADDR_W'(whole);
        bit_mask_o     <= MASK_LEFT >> bitk_q;
        write_color_o  <= bit_color;
        plane_index_o  <= '0;
        plane_data_o   <= '0;
      end else begin
        write_op_o     <= OP_MASKED;
        byte_address_o <= cache_addr_q;
        bit_mask_o     <= cache_mask_q;
        write_color_o  <= cache_color_q;
        plane_index_o  <= '0;
        plane_data_o   <= '0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_cache_run_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cache_valid_q && (run_len_q != '0)))
    else $error("cache and run both pending");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_len_q <= LEN_W'(RUN_PIXELS))
    else $error("run longer than buffer");

  a_plane_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && (write_op_o == OP_PLANE)) |-> (bit_mask_o == MASK_FULL))
    else $error("plane write without full mask");
`endif

endmodule

// ===== sv/planar_pixel_write_combiner_core.sv =====
// Top level of the planar pixel write combiner: controller plus datapath.
//
//  channel  | handshake            | beat fields
//  ---------+----------------------+-------------------------------------------------
//  item in  | start_i && !busy_o   | kind_i, pixel_x_i, pixel_y_i, pixel_color_i
//  write out| strobe_o (no stall)  | write_op_o, byte_address_o, bit_mask_o,
//           |                      | write_color_o, plane_index_o, plane_data_o, last_o
//
// An item that causes at most one write passes the accept edge, which registers
// the byte address and linear position, and the decide cycle, which compares
// against the cache and the pending run. A run flush then walks its beats with
// the byte/plane and bit counters (up to 35 beats); busy_o stays high until the
// last beat is issued. Each beat shows for exactly one cycle after it is issued,
// and a new item can be accepted meanwhile. Reset clears the cache valid flag,
// the run length, the write strobe and the controller; the plane buffer is not
// cleared, since unwritten bits never reach the outputs.
module planar_pixel_write_combiner_core #(
  parameter int unsigned RUN_PIXELS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        kind_i,
  input  logic [9:0]  pixel_x_i,
  input  logic [8:0]  pixel_y_i,
  input  logic [3:0]  pixel_color_i,
  output logic        strobe_o,
  output logic        write_op_o,
  output logic [15:0] byte_address_o,
  output logic [7:0]  bit_mask_o,
  output logic [3:0]  write_color_o,
  output logic [1:0]  plane_index_o,
  output logic [7:0]  plane_data_o,
  output logic        last_o
);
  import ppwc_pkg::*;

  // commands down, status up; nothing else crosses between the two halves
  ppwc_cmd_t    cmd;
  ppwc_status_t status;

  ppwc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  ppwc_dp #(
    .RUN_PIXELS (RUN_PIXELS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .kind_i         (kind_i),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .pixel_color_i  (pixel_color_i),
    .strobe_o       (strobe_o),
    .write_op_o     (write_op_o),
    .byte_address_o (byte_address_o),
    .bit_mask_o     (bit_mask_o),
    .write_color_o  (write_color_o),
    .plane_index_o  (plane_index_o),
    .plane_data_o   (plane_data_o),
    .last_o         (last_o)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the planar pixel write combiner core.
`timescale 1ns / 100ps

module tb_top;
  import ppwc_pkg::*;

  localparam int unsigned RUN_LEN      = 64;
  localparam int unsigned ROW_PIXELS   = 640;
  localparam int unsigned ROW_BYTES    = 80;
  localparam int unsigned X_MAX        = 1023;  // full 10-bit column range
  localparam int unsigned Y_MAX        = 511;   // full 9-bit row range
  localparam int unsigned MAX_GAP      = 18;
  localparam int unsigned RAND_ITEMS   = 280;
  localparam int unsigned DRAIN_CYCLES = 60;    // > longest flush walk of 35 beats

  // One pixel or flush command as the CPU side issues it
  typedef struct {
    logic        kind;
    logic [9:0]  x;
    logic [8:0]  y;
    logic [3:0]  color;
    int unsigned gap;    // idle cycles before this command is presented
  } pixel_cmd_t;

  // One framebuffer write as it should leave the block
  typedef struct {
    logic        op;
    logic [15:0] addr;
    logic [7:0]  mask;
    logic [3:0]  color;
    logic [1:0]  plane;
    logic [7:0]  data;
    logic        last;
  } fb_write_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        start_i       = 1'b0;
  logic        kind_i        = KIND_PIXEL;
  logic [9:0]  pixel_x_i     = '0;
  logic [8:0]  pixel_y_i     = '0;
  logic [3:0]  pixel_color_i = '0;
  logic        busy_o;
  logic        strobe_o;
  logic        write_op_o;
  logic [15:0] byte_address_o;
  logic [7:0]  bit_mask_o;
  logic [3:0]  write_color_o;
  logic [1:0]  plane_index_o;
  logic [7:0]  plane_data_o;
  logic        last_o;

  planar_pixel_write_combiner_core #(
    .RUN_PIXELS(RUN_LEN)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .kind_i        (kind_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .pixel_color_i (pixel_color_i),
    .strobe_o      (strobe_o),
    .write_op_o    (write_op_o),
    .byte_address_o(byte_address_o),
    .bit_mask_o    (bit_mask_o),
    .write_color_o (write_color_o),
    .plane_index_o (plane_index_o),
    .plane_data_o  (plane_data_o),
    .last_o        (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------
  // Shadow copy of the combiner: plane buffers, cached masked write and
  // the pending run. Updated at every accepted beat on the input side.
  // ------------------------------------------------------------------
  logic [7:0]  shadow_planes [NUM_PLANES][PLANE_BYTES];
  bit          shadow_cache_valid;
  int unsigned shadow_cache_addr;
  int unsigned shadow_cache_color;
  int unsigned shadow_cache_mask;
  int unsigned shadow_run_start;   // linear position y*640+x of run pixel 0
  int unsigned shadow_run_len;

  fb_write_t   fb_writes_q[$];     // writes predicted but not yet seen
  pixel_cmd_t  cmd_q[$];           // commands not yet presented
  bit          calm;               // stretch with no idle cycles
  int unsigned acc_count;          // beats accepted on the input side
  int unsigned sent_count;         // beats presented by the driver
  int unsigned idle_left;
  int          fail_count;

  function automatic void post_write(logic op, int unsigned addr, int unsigned mask,
                                     int unsigned color, int unsigned plane,
                                     logic [7:0] data);
    fb_write_t w;
    w.op    = op;
    w.addr  = 16'(addr);
    w.mask  = 8'(mask);
    w.color = 4'(color);
    w.plane = 2'(plane);
    w.data  = data;
    w.last  = 1'b0;
    fb_writes_q.push_back(w);
  endfunction

  function automatic void drain_cache();
    if (shadow_cache_valid)
      post_write(OP_MASKED, shadow_cache_addr, shadow_cache_mask, shadow_cache_color, 0,
                 8'h00);
    shadow_cache_valid = 1'b0;
    shadow_cache_mask  = 0;
  endfunction

  // Whole bytes go out plane 3 first, then leftover pixels as one-bit
  // masked writes, highest pixel index first.
  function automatic void drain_run();
    int unsigned base;
    int unsigned whole;
    int unsigned hue;
    int unsigned sel;
    int          p;
    int unsigned b;
    base  = (shadow_run_start >> 3) & 32'hFFFF;
    whole = shadow_run_len >> 3;
    if (whole > PLANE_BYTES) whole = PLANE_BYTES;
    if (whole > 0) begin
      for (p = NUM_PLANES - 1; p >= 0; p--) begin
        for (b = 0; b < whole; b++)
          post_write(OP_PLANE, base + b, MASK_FULL, 0, p, shadow_planes[p][b]);
        // byte after the whole ones moves to the front; may be stale
        if (whole < PLANE_BYTES) shadow_planes[p][0] = shadow_planes[p][whole];
      end
      base = (base + whole) & 32'hFFFF;
    end
    shadow_run_len = shadow_run_len & 7;
    while (shadow_run_len != 0) begin
      shadow_run_len--;
      sel = 32'(MASK_LEFT) >> shadow_run_len;
      hue = 0;
      for (p = 0; p < NUM_PLANES; p++)
        if ((32'(shadow_planes[p][0]) & sel) != 0) hue = hue | (1 << p);
      post_write(OP_MASKED, base, sel, hue, 0, 8'h00);
    end
    shadow_cache_valid = 1'b0;
    shadow_cache_mask  = 0;
    shadow_cache_addr  = base;
  endfunction

  function automatic void store_pixel(int unsigned idx, logic [3:0] color);
    int unsigned slot;
    logic [7:0]  sel;
    int          p;
    slot = (idx >> 3) & (PLANE_BYTES - 1);
    sel  = MASK_LEFT >> (idx & 7);
    for (p = 0; p < NUM_PLANES; p++)
      if (color[p]) shadow_planes[p][slot] = shadow_planes[p][slot] | sel;
      else          shadow_planes[p][slot] = shadow_planes[p][slot] & ~sel;
  endfunction

  function automatic void predict_writes(logic kind, logic [9:0] x, logic [8:0] y,
                                         logic [3:0] color);
    int unsigned addr;
    int unsigned sel;
    int unsigned lin;
    int unsigned n_before;
    bit          contig;
    fb_write_t   w;
    n_before = fb_writes_q.size();
    if (kind == KIND_FLUSH) begin
      if (shadow_run_len != 0) drain_run();
      else drain_cache();
    end else begin
      addr   = (32'(y) * ROW_BYTES + (32'(x) >> 3)) & 32'hFFFF;
      sel    = 32'(MASK_LEFT) >> x[2:0];
      lin    = (32'(y) * ROW_PIXELS + 32'(x)) & 32'h7FFFF;
      contig = 1'b0;
      if (shadow_run_len != 0) begin
        if (lin == shadow_run_start + shadow_run_len) contig = 1'b1;
        else drain_run();
      end
      if (contig) begin
        // full buffer: write it out and restart at this pixel, any column
        if (shadow_run_len >= RUN_LEN) begin
          drain_run();
          shadow_run_start = lin;
        end
        store_pixel(shadow_run_len, color);
        shadow_run_len++;
      end else if (shadow_cache_valid && shadow_cache_color == 32'(color) &&
                   shadow_cache_addr == addr) begin
        shadow_cache_mask = shadow_cache_mask | sel;
      end else if ((x[3:0] & ALIGN_MASK) == 4'h0) begin
        drain_cache();
        shadow_run_start = lin;
        store_pixel(0, color);
        shadow_run_len = 1;
      end else begin
        drain_cache();
        shadow_cache_valid = 1'b1;
        shadow_cache_addr  = addr;
        shadow_cache_mask  = sel;
        shadow_cache_color = 32'(color);
      end
    end
    if (fb_writes_q.size() > n_before) begin
      w      = fb_writes_q[fb_writes_q.size() - 1];
      w.last = 1'b1;
      fb_writes_q[fb_writes_q.size() - 1] = w;
    end
  endfunction

  function automatic void check_field(string field, logic [15:0] want_v,
                                      logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want_v, got_v);
      fail_count++;
    end
  endfunction

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  function automatic void push_cmd(logic kind, int unsigned x, int unsigned y,
                                   int unsigned color);
    pixel_cmd_t cmd;
    cmd.kind  = kind;
    cmd.x     = 10'(x);
    cmd.y     = 9'(y);
    cmd.color = 4'(color);
    cmd.gap   = calm ? 0 : $urandom_range(0, MAX_GAP);
    cmd_q.push_back(cmd);
  endfunction

  // Pixels in linear order from (x0, y0). At the row end the next pixel is
  // either x+1 on the same row or x=0 on the next: both are contiguous.
  // A rough run sometimes gets broken by a skipped pixel or a flush.
  function automatic void queue_run(int unsigned x0, int unsigned y0, int unsigned len,
                                    bit rough);
    int unsigned xv;
    int unsigned yv;
    int unsigned lin;
    int unsigned hue;
    int unsigned i;
    xv  = x0;
    yv  = y0;
    hue = $urandom_range(0, 15);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 3) == 0) hue = $urandom_range(0, 15);
      if (rough && $urandom_range(0, 24) == 0) begin
        if ($urandom_range(0, 1) == 1) push_cmd(KIND_FLUSH, $urandom, $urandom, $urandom);
        else xv++;
      end
      if (xv > X_MAX) begin
        lin = yv * ROW_PIXELS + xv;
        xv  = lin % ROW_PIXELS;
        yv  = lin / ROW_PIXELS;
      end
      if (yv > Y_MAX) break;
      push_cmd(KIND_PIXEL, xv, yv, hue);
      if (xv == ROW_PIXELS - 1 && $urandom_range(0, 1) == 1) begin
        xv = 0;
        yv++;
      end else begin
        xv++;
      end
    end
  endfunction

  // ------------------------------------------------------------------
  // Driver: presents commands at the falling edge, holds start_i until
  // the beat is taken, then waits the next command's idle gap.
  // ------------------------------------------------------------------
  always @(negedge clk_i) begin
    pixel_cmd_t cmd;
    logic       present;
    logic       load;
    present = start_i;
    load    = 1'b0;
    if (rst_ni) begin
      if (start_i && acc_count == sent_count) begin
        present = 1'b0;
        if (cmd_q.size() != 0) idle_left = cmd_q[0].gap;
      end
      if (!present) begin
        if (idle_left != 0) begin
          idle_left--;
        end else if (cmd_q.size() != 0) begin
          cmd = cmd_q.pop_front();
          load    = 1'b1;
          present = 1'b1;
          sent_count++;
        end
      end
    end
    start_i <= present;
    if (load) begin
      kind_i        <= cmd.kind;
      pixel_x_i     <= cmd.x;
      pixel_y_i     <= cmd.y;
      pixel_color_i <= cmd.color;
    end else if (!present) begin
      // junk on the fields while start_i is low must be ignored
      kind_i        <= 1'($urandom);
      pixel_x_i     <= 10'($urandom);
      pixel_y_i     <= 9'($urandom);
      pixel_color_i <= 4'($urandom);
    end
  end

  // ------------------------------------------------------------------
  // Monitor: checks a write beat against the oldest prediction first,
  // then folds an accepted input beat into the shadow state. A beat's
  // writes can never show at its own accept edge, so this order is safe.
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin
    fb_write_t want;
    if (rst_ni) begin
      if (strobe_o === 1'b1) begin
        if (fb_writes_q.size() == 0) begin
          $error("unexpected write beat: op %0d addr %0d mask %0d", write_op_o,
                 byte_address_o, bit_mask_o);
          fail_count++;
        end else begin
          want = fb_writes_q.pop_front();
          check_field("write_op", 16'(want.op), 16'(write_op_o));
          check_field("byte_address", want.addr, byte_address_o);
          check_field("bit_mask", 16'(want.mask), 16'(bit_mask_o));
          check_field("write_color", 16'(want.color), 16'(write_color_o));
          check_field("plane_index", 16'(want.plane), 16'(plane_index_o));
          check_field("plane_data", 16'(want.data), 16'(plane_data_o));
          check_field("last", 16'(want.last), 16'(last_o));
        end
      end
      if (start_i === 1'b1 && busy_o === 1'b0) begin
        predict_writes(kind_i, pixel_x_i, pixel_y_i, pixel_color_i);
        acc_count++;
      end
    end
  end

  // ------------------------------------------------------------------
  // Sequence: directed cases, then random runs, cache bursts and noise.
  // ------------------------------------------------------------------
  initial begin
    int unsigned n_total;
    int unsigned pick;
    int unsigned len;
    int unsigned xb;
    int unsigned yv;
    int unsigned hue;
    int unsigned i;
    int          p;
    for (p = 0; p < NUM_PLANES; p++)
      for (i = 0; i < PLANE_BYTES; i++) shadow_planes[p][i] = 8'h00;

    calm = 1'b0;
    // flush with nothing pending: no writes, pixel fields all ones
    push_cmd(KIND_FLUSH, X_MAX, Y_MAX, 15);
    // cached write, merge in the same byte, color change in the same byte
    push_cmd(KIND_PIXEL, 5, 0, 15);
    push_cmd(KIND_PIXEL, 7, 0, 15);
    push_cmd(KIND_PIXEL, 1, 0, 0);
    push_cmd(KIND_FLUSH, 0, 0, 0);
    // out-of-range corner, then an aligned run past the visible row end
    push_cmd(KIND_PIXEL, X_MAX, Y_MAX, 0);
    queue_run(1008, Y_MAX, 9, 1'b0);
    push_cmd(KIND_FLUSH, 0, 0, 0);
    // one whole byte and no leftover: the stale byte after it moves up
    queue_run(16, 479, 8, 1'b0);
    push_cmd(KIND_PIXEL, 100, 0, 9);
    push_cmd(KIND_FLUSH, 0, 0, 0);

    // full buffer: a continuing pixel after 64 restarts the run at x=64
    queue_run(0, 0, RUN_LEN + 6, 1'b0);
    while (cmd_q.size() < RAND_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        case ($urandom_range(0, 3))
          0:       len = $urandom_range(1, 7);
          1:       len = $urandom_range(8, 24);
          2:       len = $urandom_range(25, RUN_LEN - 1);
          default: len = $urandom_range(RUN_LEN, RUN_LEN + 8);
        endcase
        xb = 16 * $urandom_range(0, ($urandom_range(0, 3) == 0) ? 63 : 39);
        queue_run(xb, $urandom_range(0, Y_MAX), len, 1'b1);
        if ($urandom_range(0, 2) == 0) push_cmd(KIND_FLUSH, $urandom, $urandom, $urandom);
      end else if (pick < 8) begin
        // several pixels into one byte, mostly one color
        xb  = 8 * $urandom_range(0, X_MAX / 8);
        yv  = $urandom_range(0, Y_MAX);
        hue = $urandom_range(0, 15);
        len = $urandom_range(2, 8);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(0, 4) == 0) hue = $urandom_range(0, 15);
          push_cmd(KIND_PIXEL, xb + $urandom_range(0, 7), yv, hue);
        end
      end else if (pick == 8) begin
        push_cmd(KIND_FLUSH, $urandom, $urandom, $urandom);
      end else begin
        push_cmd(1'($urandom), $urandom, $urandom, $urandom);
      end
    end
    n_total = cmd_q.size();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (acc_count < n_total) @(posedge clk_i);
    while (fb_writes_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
